>>> rtl/cbm_pkg.sv
// Shared types, codes and constants of the cartridge bank mapper.
package cbm_pkg;

   // Default sizes of the bank number fields
   localparam int CBM_ROM_BANK_BITS = 9;
   localparam int CBM_RAM_BANK_BITS = 4;

   localparam int ROM_ADDR_W = 23;
   localparam int RAM_ADDR_W = 17;

   // Special bus addresses and data values
   localparam logic [15:0] BOOT_OFF_ADDR  = 16'hFF50;
   localparam logic [7:0]  RAM_ENABLE_KEY = 8'h0A;
   localparam logic [3:0]  RAM_ENABLE_NIB = 4'hA;
   localparam logic [7:0]  OPEN_BUS_BYTE  = 8'hFF;
   localparam logic [7:0]  M2_NIBBLE_FILL = 8'hF0;

   // Clock register select values (RAM bank register on mapper3)
   localparam logic [7:0] CLK_REG_SECONDS = 8'h08;
   localparam logic [7:0] CLK_REG_MINUTES = 8'h09;
   localparam logic [7:0] CLK_REG_HOURS   = 8'h0A;
   localparam logic [7:0] CLK_REG_DAYS_LO = 8'h0B;
   localparam logic [7:0] CLK_REG_CONTROL = 8'h0C;

   typedef enum logic [1:0] {
      KIND_M1 = 2'd0,
      KIND_M2 = 2'd1,
      KIND_M3 = 2'd2,
      KIND_M5 = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_MAPPER_KIND   = 2'd0,
      CSR_ROM_BANK_MASK = 2'd1,
      CSR_RAM_BANK_MASK = 2'd2,
      CSR_MULTICART     = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      TGT_NONE     = 3'd0,
      TGT_BOOT_ROM = 3'd1,
      TGT_CART_ROM = 3'd2,
      TGT_EXT_RAM  = 3'd3,
      TGT_CLOCK    = 3'd4,
      TGT_OPEN_BUS = 3'd5
   } target_type;

   // Clock registers, packed so that seconds sit at bits 5:0
   typedef struct packed {
      logic       day_carry;
      logic       halt;
      logic [8:0] days;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } clock_regs_type;

   typedef struct packed {
      logic [8:0]     rom_page;
      logic [7:0]     ram_page;
      logic           ram_enabled;
      logic           bank_mode;
      logic           boot_overlay;
      clock_regs_type live;
      logic [7:0]     latch_last_byte;
      clock_regs_type latched;
   } state_type;

   typedef struct packed {
      kind_type   kind;
      logic [8:0] rom_mask;
      logic [3:0] ram_mask;
      logic       multicart;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] address;
      logic [7:0]  data;
   } item_type;

   typedef struct packed {
      target_type              target;
      logic [ROM_ADDR_W-1:0]   rom_address;
      logic [RAM_ADDR_W-1:0]   ram_address;
      logic                    ram_write;
      logic [7:0]              write_data;
      logic [7:0]              read_data;
      logic                    persist_request;
      logic                    subsecond_reset;
   } result_type;

endpackage

>>> rtl/cbm_ifs.sv
// Request and response channel interfaces of the cartridge bank mapper.
interface cbm_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] address;
   logic [7:0]  data;

   modport source (output valid, output opcode, output address, output data, input ready);
   modport sink   (input valid, input opcode, input address, input data, output ready);
endinterface

interface cbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  target;
   logic [22:0] rom_address;
   logic [16:0] ram_address;
   logic        ram_write;
   logic [7:0]  write_data;
   logic [7:0]  read_data;
   logic        persist_request;
   logic        subsecond_reset;

   modport source (
      output valid, output target, output rom_address, output ram_address,
      output ram_write, output write_data, output read_data,
      output persist_request, output subsecond_reset, input ready
   );
   modport sink (
      input valid, input target, input rom_address, input ram_address,
      input ram_write, input write_data, input read_data,
      input persist_request, input subsecond_reset, output ready
   );
endinterface

>>> rtl/cbm_decode.sv
// Access decode: address translation and next bank/clock state for one bus word.
module cbm_decode import cbm_pkg::*; (
   input  item_type   item,
   input  cfg_type    cfg,
   input  state_type  state,
   output result_type result,
   output state_type  state_in
);

   logic       wr;
   logic [15:0] a;
   logic [7:0]  d;
   logic        en_write;
   logic        en_on;
   logic        rb_write;
   logic [8:0]  rb_raw;
   logic [8:0]  low_bank;

   always_comb begin
      wr       = (item.opcode == OP_WRITE);
      a        = item.address;
      d        = item.data;
      result   = '0;
      state_in = state;
      en_write = 1'b0;
      en_on    = 1'b0;
      rb_write = 1'b0;
      rb_raw   = state.rom_page;
      low_bank = '0;

      if (!a[15]) begin
         if (wr) begin
            // Control area write
            if (cfg.kind == KIND_M2) begin
               if (!a[14]) begin
                  if (!a[8]) begin
                     en_write = 1'b1;
                     en_on    = (d[3:0] == RAM_ENABLE_NIB);
                  end else begin
                     rb_write = 1'b1;
                     rb_raw   = (d[3:0] != 4'd0) ? {5'd0, d[3:0]} : 9'd1;
                  end
               end
            end else begin
               unique case (a[14:13])
                  2'd0: begin
                     en_write = 1'b1;
                     en_on    = (cfg.kind == KIND_M5) ? (d == RAM_ENABLE_KEY)
                                                      : (d[3:0] == RAM_ENABLE_NIB);
                  end
                  2'd1: begin
                     rb_write = 1'b1;
                     unique case (cfg.kind)
                        KIND_M1: begin
                           if (cfg.multicart)
                              rb_raw = ((d[4:0] != 5'd0) ? {5'd0, d[3:0]} : 9'd1)
                                       | (state.rom_page & 9'h030);
                           else
                              rb_raw = ((d[4:0] != 5'd0) ? {4'd0, d[4:0]} : 9'd1)
                                       | (state.rom_page & 9'h060);
                        end
                        KIND_M3: rb_raw = (d[6:0] != 7'd0) ? {2'd0, d[6:0]} : 9'd1;
                        KIND_M5: begin
                           if (!a[12])
                              rb_raw = {state.rom_page[8], d};
                           else
                              rb_raw = {d[0], state.rom_page[7:0]};
                        end
                        default: rb_raw = state.rom_page;
                     endcase
                  end
                  2'd2: begin
                     unique case (cfg.kind)
                        KIND_M1: begin
                           state_in.ram_page = {6'd0, d[1:0]};
                           rb_write = 1'b1;
                           if (cfg.multicart)
                              rb_raw = {3'd0, d[1:0], state.rom_page[3:0]};
                           else
                              rb_raw = {2'd0, d[1:0], state.rom_page[4:0]};
                        end
                        KIND_M3: state_in.ram_page = d;
                        KIND_M5: state_in.ram_page = {4'd0, d[3:0]};
                        default: state_in.ram_page = state.ram_page;
                     endcase
                  end
                  default: begin
                     if (cfg.kind == KIND_M1) begin
                        state_in.bank_mode = d[0];
                     end else if (cfg.kind == KIND_M3) begin
                        // Latch the live clock on a zero-to-one sequence
                        if (state.latch_last_byte == 8'd0 && d == 8'd1)
                           state_in.latched = state.live;
                        state_in.latch_last_byte = d;
                     end
                  end
               endcase
            end
         end else if (!a[14]) begin
            // Low ROM window, with boot overlay over the first page
            if (state.boot_overlay && a[13:8] == 6'd0) begin
               result.target      = TGT_BOOT_ROM;
               result.rom_address = {15'd0, a[7:0]};
            end else begin
               if (cfg.kind == KIND_M1 && state.bank_mode)
                  low_bank = state.rom_page & (cfg.multicart ? 9'h030 : 9'h060);
               result.target      = TGT_CART_ROM;
               result.rom_address = {low_bank, a[13:0]};
            end
         end else begin
            result.target      = TGT_CART_ROM;
            result.rom_address = {state.rom_page, a[13:0]};
         end
      end else if (a[15:13] == 3'b101) begin
         // External RAM window
         if (!state.ram_enabled) begin
            result.target    = TGT_OPEN_BUS;
            result.read_data = OPEN_BUS_BYTE;
         end else if (cfg.kind == KIND_M3 && state.ram_page >= CLK_REG_SECONDS
                      && state.ram_page <= CLK_REG_CONTROL) begin
            result.target = TGT_CLOCK;
            if (wr) begin
               unique case (state.ram_page)
                  CLK_REG_SECONDS: begin
                     state_in.live.seconds  = d[5:0];
                     result.subsecond_reset = 1'b1;
                  end
                  CLK_REG_MINUTES: state_in.live.minutes = d[5:0];
                  CLK_REG_HOURS:   state_in.live.hours   = d[4:0];
                  CLK_REG_DAYS_LO: state_in.live.days    = {state.live.days[8], d};
                  default: begin
                     state_in.live.days[8]   = d[0];
                     state_in.live.halt      = d[6];
                     state_in.live.day_carry = d[7];
                  end
               endcase
            end else begin
               unique case (state.ram_page)
                  CLK_REG_SECONDS: result.read_data = {2'd0, state.latched.seconds};
                  CLK_REG_MINUTES: result.read_data = {2'd0, state.latched.minutes};
                  CLK_REG_HOURS:   result.read_data = {3'd0, state.latched.hours};
                  CLK_REG_DAYS_LO: result.read_data = state.latched.days[7:0];
                  default: result.read_data = {state.latched.day_carry,
                                               state.latched.halt, 5'd0,
                                               state.latched.days[8]};
               endcase
            end
         end else begin
            result.target = TGT_EXT_RAM;
            if (cfg.kind == KIND_M2)
               result.ram_address = {8'd0, a[8:0]};
            else if (cfg.kind == KIND_M1 && !state.bank_mode)
               result.ram_address = {4'd0, a[12:0]};
            else
               result.ram_address = {state.ram_page[3:0] & cfg.ram_mask, a[12:0]};
            if (wr) begin
               result.ram_write  = 1'b1;
               result.write_data = (cfg.kind == KIND_M2) ? (d | M2_NIBBLE_FILL) : d;
            end
         end
      end else if (wr && a == BOOT_OFF_ADDR) begin
         state_in.boot_overlay = 1'b0;
      end

      // Apply RAM enable change, flag a save when enabled RAM turns off
      if (en_write) begin
         result.persist_request = state.ram_enabled && !en_on;
         state_in.ram_enabled   = en_on;
      end

      // Cut every new ROM bank by the mask
      if (rb_write)
         state_in.rom_page = rb_raw & cfg.rom_mask;
   end

endmodule

>>> rtl/cbm_state_regs.sv
// Bank, enable, boot overlay and clock registers of the cartridge bank mapper.
module cbm_state_regs import cbm_pkg::*; #(
   parameter int ROM_BANK_BITS = CBM_ROM_BANK_BITS
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      update,
   input  state_type state_in,
   output state_type state
);

   logic [ROM_BANK_BITS-1:0] rom_page_ff;
   logic [7:0]               ram_page_ff;
   logic                     ram_enabled_ff;
   logic                     bank_mode_ff;
   logic                     boot_overlay_ff;
   clock_regs_type           live_ff;
   logic [7:0]               latch_last_byte_ff;
   clock_regs_type           latched_ff;

   // Take the decoded next state when a word leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_page_ff        <= ROM_BANK_BITS'(1);
         ram_page_ff        <= '0;
         ram_enabled_ff     <= 1'b0;
         bank_mode_ff       <= 1'b0;
         boot_overlay_ff    <= 1'b1;
         live_ff            <= '0;
         latch_last_byte_ff <= '0;
         latched_ff         <= '0;
      end else if (update) begin
         rom_page_ff        <= state_in.rom_page[ROM_BANK_BITS-1:0];
         ram_page_ff        <= state_in.ram_page;
         ram_enabled_ff     <= state_in.ram_enabled;
         bank_mode_ff       <= state_in.bank_mode;
         boot_overlay_ff    <= state_in.boot_overlay;
         live_ff            <= state_in.live;
         latch_last_byte_ff <= state_in.latch_last_byte;
         latched_ff         <= state_in.latched;
      end
   end

   always_comb begin
      state.rom_page        = 9'(rom_page_ff);
      state.ram_page        = ram_page_ff;
      state.ram_enabled     = ram_enabled_ff;
      state.bank_mode       = bank_mode_ff;
      state.boot_overlay    = boot_overlay_ff;
      state.live            = live_ff;
      state.latch_last_byte = latch_last_byte_ff;
      state.latched         = latched_ff;
   end

endmodule

>>> rtl/cartridge_bank_mapper_unit.sv
// Cartridge bank mapper for mapper families 1 (with multicart wiring), 2, 3 and 5: each
// bus word passes an input register, one decode stage and an output register, so a
// result is decoded from the input register and offered from the output register;
// one word is taken every cycle while the response side keeps up. The bank, enable and
// clock registers are read and updated by that single decode stage, so each word sees the
// effect of the word before it. The response register holds a result while the sink
// stalls and the input register keeps taking words as long as the result moves on. Write
// the configuration registers only while no word is in flight.
module cartridge_bank_mapper_unit import cbm_pkg::*; #(
   parameter int ROM_BANK_BITS = CBM_ROM_BANK_BITS,
   parameter int RAM_BANK_BITS = CBM_RAM_BANK_BITS
) (
   input  logic       clock,
   input  logic       reset,
   cbm_req_if.sink    req_bus,
   cbm_rsp_if.source  rsp_bus,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_write_data
);

   kind_type                 kind_ff;
   logic [ROM_BANK_BITS-1:0] rom_mask_ff;
   logic [RAM_BANK_BITS-1:0] ram_mask_ff;
   logic                     multicart_ff;

   logic       in_valid_ff;
   item_type   item_ff;
   logic       out_valid_ff;
   result_type result_ff;

   logic       out_free;
   logic       advance;
   logic       accept;
   cfg_type    cfg;
   state_type  state;
   state_type  state_in;
   result_type result_in;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_M1;
         rom_mask_ff  <= ROM_BANK_BITS'(1);
         ram_mask_ff  <= '0;
         multicart_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAPPER_KIND:   kind_ff      <= kind_type'(csr_write_data[1:0]);
            CSR_ROM_BANK_MASK: rom_mask_ff  <= csr_write_data[ROM_BANK_BITS-1:0];
            CSR_RAM_BANK_MASK: ram_mask_ff  <= csr_write_data[RAM_BANK_BITS-1:0];
            default:           multicart_ff <= csr_write_data[0];
         endcase
      end
   end

   always_comb begin
      cfg.kind      = kind_ff;
      cfg.rom_mask  = 9'(rom_mask_ff);
      cfg.ram_mask  = 4'(ram_mask_ff);
      cfg.multicart = multicart_ff;
   end

   // Handshake: advance when the output register is free or being drained
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready)
            in_valid_ff <= req_bus.valid;
         if (out_free)
            out_valid_ff <= advance;
      end
   end

   // Payload registers: hold the input word and the finished result
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.opcode  <= req_bus.opcode;
         item_ff.address <= req_bus.address;
         item_ff.data    <= req_bus.data;
      end
      if (advance)
         result_ff <= result_in;
   end

   cbm_decode u_decode (
      .item     (item_ff),
      .cfg      (cfg),
      .state    (state),
      .result   (result_in),
      .state_in (state_in)
   );

   cbm_state_regs #(
      .ROM_BANK_BITS (ROM_BANK_BITS)
   ) u_state_regs (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .state_in (state_in),
      .state    (state)
   );

   // Drive the response channel from the output register
   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.target          = result_ff.target;
   assign rsp_bus.rom_address     = result_ff.rom_address;
   assign rsp_bus.ram_address     = result_ff.ram_address;
   assign rsp_bus.ram_write       = result_ff.ram_write;
   assign rsp_bus.write_data      = result_ff.write_data;
   assign rsp_bus.read_data       = result_ff.read_data;
   assign rsp_bus.persist_request = result_ff.persist_request;
   assign rsp_bus.subsecond_reset = result_ff.subsecond_reset;

endmodule

>>> rtl/cbm_checker.sv
// Port-level checks of the cartridge bank mapper, bound to the top level.
module cbm_checker import cbm_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_target,
   input logic [22:0] rsp_rom_address,
   input logic        rsp_ram_write,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_persist_request,
   input logic        rsp_subsecond_reset
);

   // No result is shown right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target)
                                   && $stable(rsp_rom_address))
      else $error("stalled response changed");

   // Open bus reads 0xFF and never writes RAM
   a_open_bus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target == TGT_OPEN_BUS |-> rsp_read_data == OPEN_BUS_BYTE
                                                  && !rsp_ram_write)
      else $error("open bus word carries data or a RAM write");

   // RAM writes only go to external RAM
   a_ram_write_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ram_write |-> rsp_target == TGT_EXT_RAM)
      else $error("RAM write outside external RAM");

   // Side flags belong to their own kind of access
   a_side_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_subsecond_reset |-> rsp_target == TGT_CLOCK
                                          && !rsp_persist_request)
      else $error("subsecond reset on a non-clock word");

endmodule

bind cartridge_bank_mapper_unit cbm_checker u_cbm_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_target          (rsp_bus.target),
   .rsp_rom_address     (rsp_bus.rom_address),
   .rsp_ram_write       (rsp_bus.ram_write),
   .rsp_read_data       (rsp_bus.read_data),
   .rsp_persist_request (rsp_bus.persist_request),
   .rsp_subsecond_reset (rsp_bus.subsecond_reset)
);
